/* src/oqpi_pkg.sv */
// package for the ordered queue with positional insert
// opcodes, status codes, cell command struct and default sizes; no dependencies
package oqpi_pkg;

	localparam int DEF_CAPACITY    = 16;
	localparam int DEF_COORD_WIDTH = 16;
	localparam int PORT_COORD_W    = 16;
	localparam int POS_W           = 5;
	localparam int OCC_W           = 5;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_SEARCH = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic shift_back;
		logic load;
		logic shift_fwd;
	} cell_cmd_t;

endpackage

/* src/oqpi_cell.sv */
// one storage cell of the queue: holds one pair, shifts to/from its neighbors
// and compares its pair against the search key; uses oqpi_pkg
module oqpi_cell #(
	parameter int IDX     = 0,
	parameter int IDX_W   = 4,
	parameter int CNT_W   = 5,
	parameter int STORE_W = 16
) (
	input  logic                clk,
	input  oqpi_pkg::cell_cmd_t cmd,
	input  logic [IDX_W-1:0]    tgt,
	input  logic [CNT_W-1:0]    cnt,
	input  logic [STORE_W-1:0]  new_x,
	input  logic [STORE_W-1:0]  new_y,
	input  logic [STORE_W-1:0]  prev_x,
	input  logic [STORE_W-1:0]  prev_y,
	input  logic [STORE_W-1:0]  next_x,
	input  logic [STORE_W-1:0]  next_y,
	output logic [STORE_W-1:0]  cell_x,
	output logic [STORE_W-1:0]  cell_y,
	output logic                match
);

	logic [STORE_W-1:0] x_q;
	logic [STORE_W-1:0] y_q;
	logic               above_tgt;
	logic               at_tgt;

	assign above_tgt = IDX_W'(IDX) > tgt;
	assign at_tgt    = IDX_W'(IDX) == tgt;

	always_ff @(posedge clk) begin
		if (cmd.shift_back && above_tgt) begin
			x_q <= prev_x;
			y_q <= prev_y;
		end else if (cmd.load && at_tgt) begin
			x_q <= new_x;
			y_q <= new_y;
		end else if (cmd.shift_fwd) begin
			x_q <= next_x;
			y_q <= next_y;
		end
	end

	assign cell_x = x_q;
	assign cell_y = y_q;
	assign match  = (CNT_W'(IDX) < cnt) && (x_q == new_x) && (y_q == new_y);

endmodule

/* src/ordered_queue_with_positional_insert.sv */
// top level of the ordered queue with positional insert
// row of oqpi_cell instances plus count, command decode and result register; uses oqpi_pkg
//
// Bounded queue of (x,y) pairs held in a row of CAPACITY cells, front at cell 0.
// Every operation (append, insert at position, remove head, search) works on
// the whole row: all cells shift or compare in the same cycle, so one item is taken
// per cycle while the result register can be emptied. Each item gives exactly one
// result with a status code, the search flag, the removed pair and the occupancy
// after the operation. No clearing pass is needed after reset.
module ordered_queue_with_positional_insert #(
	parameter int CAPACITY    = oqpi_pkg::DEF_CAPACITY,
	parameter int COORD_WIDTH = oqpi_pkg::DEF_COORD_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [4:0]  position,
	input  logic [15:0] item_x,
	input  logic [15:0] item_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [15:0] removed_x,
	output logic [15:0] removed_y,
	output logic [4:0]  occupancy
);

	localparam int STORE_W = (COORD_WIDTH < oqpi_pkg::PORT_COORD_W) ?
		COORD_WIDTH : oqpi_pkg::PORT_COORD_W;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > oqpi_pkg::POS_W) ? CNT_W : oqpi_pkg::POS_W;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	logic               xfer;
	logic               full;
	logic               empty;
	logic               pos_bad;
	logic [STORE_W-1:0] key_x;
	logic [STORE_W-1:0] key_y;
	logic [IDX_W-1:0]   tgt;
	oqpi_pkg::cell_cmd_t cmd;
	oqpi_pkg::cell_cmd_t cmd_gated;
	logic [1:0]         st_d;
	logic               found_d;
	logic [15:0]        rx_d;
	logic [15:0]        ry_d;

	logic [STORE_W-1:0] cx [CAPACITY];
	logic [STORE_W-1:0] cy [CAPACITY];
	logic [CAPACITY-1:0] hit;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        found_q;
	logic [15:0] removed_x_q;
	logic [15:0] removed_y_q;
	logic [4:0]  occupancy_q;

	assign in_ready = !out_valid_q || out_ready;
	assign xfer     = in_valid && in_ready;
	assign key_x    = item_x[STORE_W-1:0];
	assign key_y    = item_y[STORE_W-1:0];
	assign full     = cnt_q == CNT_W'(CAPACITY);
	assign empty    = cnt_q == '0;
	assign pos_bad  = CMP_W'(position) > CMP_W'(cnt_q);

	always_comb begin
		cmd     = '0;
		tgt     = IDX_W'(cnt_q);
		st_d    = oqpi_pkg::ST_OK;
		found_d = 1'b0;
		rx_d    = '0;
		ry_d    = '0;
		cnt_d   = cnt_q;
		case (opcode)
			oqpi_pkg::OP_APPEND: begin
				if (full) begin
					st_d = oqpi_pkg::ST_FULL;
				end else begin
					cmd.load = 1'b1;
					cnt_d    = cnt_q + 1'b1;
				end
			end
			oqpi_pkg::OP_INSERT: begin
				tgt = IDX_W'(CMP_W'(position));
				if (pos_bad) begin
					st_d = oqpi_pkg::ST_RANGE;
				end else if (full) begin
					st_d = oqpi_pkg::ST_FULL;
				end else begin
					cmd.shift_back = 1'b1;
					cmd.load       = 1'b1;
					cnt_d          = cnt_q + 1'b1;
				end
			end
			oqpi_pkg::OP_REMOVE: begin
				if (empty) begin
					st_d = oqpi_pkg::ST_EMPTY;
				end else begin
					cmd.shift_fwd = 1'b1;
					rx_d          = 16'(signed'(cx[0]));
					ry_d          = 16'(signed'(cy[0]));
					cnt_d         = cnt_q - 1'b1;
				end
			end
			default: begin
				found_d = |hit;
			end
		endcase
	end

	assign cmd_gated = xfer ? cmd : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [STORE_W-1:0] px, py, nx, ny;
		if (i == 0) begin : g_first
			assign px = key_x;
			assign py = key_y;
		end else begin : g_mid_p
			assign px = cx[i-1];
			assign py = cy[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign nx = cx[i];
			assign ny = cy[i];
		end else begin : g_mid_n
			assign nx = cx[i+1];
			assign ny = cy[i+1];
		end
		oqpi_cell #(
			.IDX     (i),
			.IDX_W   (IDX_W),
			.CNT_W   (CNT_W),
			.STORE_W (STORE_W)
		) u_cell (
			.clk    (clk),
			.cmd    (cmd_gated),
			.tgt    (tgt),
			.cnt    (cnt_q),
			.new_x  (key_x),
			.new_y  (key_y),
			.prev_x (px),
			.prev_y (py),
			.next_x (nx),
			.next_y (ny),
			.cell_x (cx[i]),
			.cell_y (cy[i]),
			.match  (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q    <= st_d;
			found_q     <= found_d;
			removed_x_q <= rx_d;
			removed_y_q <= ry_d;
			occupancy_q <= oqpi_pkg::OCC_W'(cnt_d);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign removed_x = removed_x_q;
	assign removed_y = removed_y_q;
	assign occupancy = occupancy_q;

endmodule

/* sim/tb_top.sv */
// testbench for ordered_queue_with_positional_insert: directed and random queue operations
// with random idling on both valid/ready channels, each result checked against a local model
// depends on oqpi_pkg and the ordered_queue_with_positional_insert top level
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = oqpi_pkg::DEF_CAPACITY;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [15:0] removed_x;
		logic [15:0] removed_y;
		logic [4:0]  occupancy;
	} queue_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [4:0]  position;
	logic [15:0] item_x;
	logic [15:0] item_y;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        found;
	logic [15:0] removed_x;
	logic [15:0] removed_y;
	logic [4:0]  occupancy;

	// local copy of the queue contents
	logic [15:0] mdl_x [CAP];
	logic [15:0] mdl_y [CAP];
	int          mdl_count;

	queue_result_t expected_results[$];
	int          mismatches;
	int          transfers_in;
	int          results_checked;
	int          status_seen [4];
	int          search_hits;
	bit          no_idle;
	bit          filling;

	ordered_queue_with_positional_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.position  (position),
		.item_x    (item_x),
		.item_y    (item_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found     (found),
		.removed_x (removed_x),
		.removed_y (removed_y),
		.occupancy (occupancy)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic place_pair(input int pos, input logic [15:0] x, input logic [15:0] y);
		int i;
		for (i = mdl_count; i > pos; i--) begin
			mdl_x[i] = mdl_x[i - 1];
			mdl_y[i] = mdl_y[i - 1];
		end
		mdl_x[pos] = x;
		mdl_y[pos] = y;
		mdl_count++;
	endtask

	task automatic predict_queue_op(input logic [1:0] op, input logic [4:0] pos,
			input logic [15:0] x, input logic [15:0] y, output queue_result_t r);
		int i;
		r = '0;
		r.status = oqpi_pkg::ST_OK;
		case (op)
			oqpi_pkg::OP_APPEND: begin
				if (mdl_count >= CAP)
					r.status = oqpi_pkg::ST_FULL;
				else
					place_pair(mdl_count, x, y);
			end
			oqpi_pkg::OP_INSERT: begin
				if (int'(pos) > mdl_count)
					r.status = oqpi_pkg::ST_RANGE;
				else if (mdl_count >= CAP)
					r.status = oqpi_pkg::ST_FULL;
				else
					place_pair(int'(pos), x, y);
			end
			oqpi_pkg::OP_REMOVE: begin
				if (mdl_count == 0) begin
					r.status = oqpi_pkg::ST_EMPTY;
				end else begin
					r.removed_x = mdl_x[0];
					r.removed_y = mdl_y[0];
					for (i = 1; i < mdl_count; i++) begin
						mdl_x[i - 1] = mdl_x[i];
						mdl_y[i - 1] = mdl_y[i];
					end
					mdl_count--;
				end
			end
			default: begin
				for (i = 0; i < mdl_count; i++)
					if (mdl_x[i] == x && mdl_y[i] == y)
						r.found = 1'b1;
			end
		endcase
		r.occupancy = mdl_count[4:0];
	endtask

	task automatic send_item(input logic [1:0] op, input logic [4:0] pos,
			input logic [15:0] x, input logic [15:0] y);
		int gap;
		queue_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		position <= pos;
		item_x   <= x;
		item_y   <= y;
		do @(posedge clk); while (!in_ready);
		predict_queue_op(op, pos, x, y, r);
		expected_results.push_back(r);
		transfers_in++;
	endtask

	function automatic logic [15:0] draw_coord();
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 4))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				3: return 16'hffff;
				default: return 16'h0001;
			endcase
		end
		return 16'($urandom);
	endfunction

	task automatic random_queue_ops(input int n);
		int k;
		int sel;
		int pick;
		logic [1:0] op;
		logic [4:0] pos;
		logic [15:0] x;
		logic [15:0] y;
		for (k = 0; k < n; k++) begin
			if (mdl_count >= CAP)
				filling = 1'b0;
			else if (mdl_count == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = ~filling;
			sel = $urandom_range(0, 99);
			if (sel < 20)
				op = oqpi_pkg::OP_SEARCH;
			else if (sel < (filling ? 80 : 40))
				op = ($urandom_range(0, 1) == 0) ? oqpi_pkg::OP_APPEND : oqpi_pkg::OP_INSERT;
			else
				op = oqpi_pkg::OP_REMOVE;
			x = draw_coord();
			y = draw_coord();
			if (op == oqpi_pkg::OP_SEARCH && mdl_count > 0 && $urandom_range(0, 9) < 6) begin
				pick = $urandom_range(0, mdl_count - 1);
				x = mdl_x[pick];
				y = mdl_y[pick];
			end
			if (op != oqpi_pkg::OP_INSERT || $urandom_range(0, 9) == 0)
				pos = 5'($urandom_range(0, 31));
			else
				pos = 5'($urandom_range(0, mdl_count));
			send_item(op, pos, x, y);
		end
	endtask

	task automatic test_empty_queue();
		send_item(oqpi_pkg::OP_REMOVE, 5'd0, 16'h0000, 16'h0000);
		send_item(oqpi_pkg::OP_SEARCH, 5'd0, 16'h0000, 16'h0000);
		send_item(oqpi_pkg::OP_INSERT, 5'd1, 16'h1234, 16'h5678);
		send_item(oqpi_pkg::OP_INSERT, 5'd31, 16'hffff, 16'hffff);
	endtask

	task automatic test_fill_to_capacity();
		int k;
		send_item(oqpi_pkg::OP_APPEND, 5'd0, 16'h8000, 16'h7fff);
		send_item(oqpi_pkg::OP_APPEND, 5'd31, 16'h7fff, 16'h8000);
		send_item(oqpi_pkg::OP_INSERT, 5'd0, 16'h0000, 16'h0000);
		send_item(oqpi_pkg::OP_INSERT, 5'd2, 16'hffff, 16'hffff);
		send_item(oqpi_pkg::OP_INSERT, 5'd4, 16'h0001, 16'hffff);
		send_item(oqpi_pkg::OP_SEARCH, 5'd0, 16'h7fff, 16'h8000);
		send_item(oqpi_pkg::OP_SEARCH, 5'd0, 16'h7fff, 16'h7fff);
		for (k = 0; k < 11; k++)
			send_item((k % 2) ? oqpi_pkg::OP_APPEND : oqpi_pkg::OP_INSERT, 5'(k % 3),
				draw_coord(), draw_coord());
		send_item(oqpi_pkg::OP_APPEND, 5'd0, 16'h2222, 16'h3333);
		send_item(oqpi_pkg::OP_INSERT, 5'd16, 16'h2222, 16'h3333);
		// out of range wins over full
		send_item(oqpi_pkg::OP_INSERT, 5'd17, 16'h2222, 16'h3333);
		send_item(oqpi_pkg::OP_REMOVE, 5'd0, 16'h0000, 16'h0000);
	endtask

	task automatic test_random_mix(input int n);
		no_idle = 1'b0;
		random_queue_ops(n);
	endtask

	task automatic test_back_to_back(input int n);
		no_idle = 1'b1;
		random_queue_ops(n);
		no_idle = 1'b0;
	endtask

	// receive side: random stall before each result transfer, none in back-to-back runs
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: status %0d occupancy %0d",
						status, occupancy);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				status_seen[want.status]++;
				if (want.found)
					search_hits++;
				if (status !== want.status || found !== want.found
						|| removed_x !== want.removed_x || removed_y !== want.removed_y
						|| occupancy !== want.occupancy) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result %0d: expected st %0d fnd %0d rx %h ry %h occ %0d,",
							" got st %0d fnd %0d rx %h ry %h occ %0d"}, results_checked,
							want.status, want.found, want.removed_x, want.removed_y,
							want.occupancy, status, found, removed_x, removed_y, occupancy);
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("ordered_queue_with_positional_insert: mismatch");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = oqpi_pkg::OP_APPEND;
		position   = '0;
		item_x     = '0;
		item_y     = '0;
		mdl_count  = 0;
		mismatches = 0;
		no_idle    = 1'b0;
		filling    = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_to_capacity();
		test_random_mix(500);
		test_back_to_back(200);
		test_random_mix(430);

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d input transfers and %0d checked results", transfers_in,
			results_checked);
		$display("status ok %0d, empty %0d, range %0d, full %0d; search hits %0d",
			status_seen[oqpi_pkg::ST_OK], status_seen[oqpi_pkg::ST_EMPTY],
			status_seen[oqpi_pkg::ST_RANGE], status_seen[oqpi_pkg::ST_FULL], search_hits);
		if (mismatches == 0)
			$display("ordered_queue_with_positional_insert: match");
		else
			$display("ordered_queue_with_positional_insert: mismatch");
		$finish;
	end

endmodule
